/* hw/rtl/wav_header_duration_parser_macros.svh */
// Assertion macros for the WAV header duration parser.
`ifndef WAV_HEADER_DURATION_PARSER_MACROS_SVH
`define WAV_HEADER_DURATION_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define WHDP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WHDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WHDP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define WHDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/whdp_pkg.sv */
package whdp_pkg;

   typedef enum logic [3:0] {
      PH_RIFF,
      PH_HEAD,
      PH_FMT,
      PH_SKIP,
      PH_DONE,
      PH_MUL_A,
      PH_MUL_B,
      PH_CHECK,
      PH_DIV
   } whdp_state_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_NO_DATA    = 2'd2,
      STATUS_ZERO_RATE  = 2'd3
   } whdp_status_type;

   localparam logic [31:0] TAG_DATA     = 32'h64617461;
   localparam logic [31:0] TAG_FMT      = 32'h666D7420;
   localparam logic [31:0] FMT_BODY_LEN = 32'd16;
   localparam int          BYTE_SHIFT   = 3;

   localparam logic [3:0] RIFF_LAST = 4'd11;
   localparam logic [3:0] HEAD_LAST = 4'd7;
   localparam logic [3:0] FMT_LAST  = 4'd15;

   localparam logic [3:0] FMT_CH_LO   = 4'd2;
   localparam logic [3:0] FMT_CH_HI   = 4'd3;
   localparam logic [3:0] FMT_RATE_B0 = 4'd4;
   localparam logic [3:0] FMT_RATE_B1 = 4'd5;
   localparam logic [3:0] FMT_RATE_B2 = 4'd6;
   localparam logic [3:0] FMT_RATE_B3 = 4'd7;
   localparam logic [3:0] FMT_BITS_LO = 4'd14;

   localparam int          DIV_STEPS = 32;
   localparam int          DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam int RSP_TDATA_W = 72;

   typedef struct packed {
      logic            riff_step;
      logic            head_step;
      logic            fmt_step;
      logic            fmt_commit;
      logic            skip_load;
      logic            skip_step;
      logic [3:0]      count;
      logic            clear;
      logic            mul_a;
      logic            mul_b;
      logic            div_init;
      logic            div_step;
      logic            emit;
      whdp_status_type emit_status;
      logic            emit_quot;
   } whdp_cmd_type;

   typedef struct packed {
      logic header_good_next;
      logic tag_is_data;
      logic tag_is_fmt;
      logic len_next_short;
      logic len_next_zero;
      logic fmt_len_is16;
      logic skip_leave;
      logic bps_zero;
      logic out_free;
   } whdp_sts_type;

   function automatic logic [7:0] riff_byte(input logic [3:0] idx);
      logic [7:0] value;
      case (idx)
         4'd0:    value = 8'h52;
         4'd1:    value = 8'h49;
         4'd2:    value = 8'h46;
         4'd3:    value = 8'h46;
         4'd8:    value = 8'h57;
         4'd9:    value = 8'h41;
         4'd10:   value = 8'h56;
         4'd11:   value = 8'h45;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

   function automatic logic riff_checked(input logic [3:0] idx);
      return (idx inside {[4'd0:4'd3], [4'd8:4'd11]});
   endfunction

endpackage

/* hw/rtl/whdp_ctrl.sv */
module whdp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  whdp_pkg::whdp_sts_type sts,
   output whdp_pkg::whdp_cmd_type cmd
);

   whdp_pkg::whdp_state_type state_ff, state_in;
   logic [3:0]                count_ff, count_in;
   logic [whdp_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                      eof_pending_ff, eof_pending_in;

   logic                      parse_state;
   logic                      accept;
   logic                      riff_end;
   logic                      head_end;
   logic                      fmt_end;
   logic                      start_calc;
   logic                      byte_emit;
   whdp_pkg::whdp_status_type byte_status;
   logic                      eof_emit;
   whdp_pkg::whdp_state_type  phase_after;
   logic [3:0]                count_after;

   always_comb begin
      parse_state = (state_ff inside {whdp_pkg::PH_RIFF, whdp_pkg::PH_HEAD, whdp_pkg::PH_FMT,
                                      whdp_pkg::PH_SKIP, whdp_pkg::PH_DONE});
      req_tready  = parse_state && sts.out_free;
      accept      = req_tvalid && req_tready;
      riff_end    = (state_ff == whdp_pkg::PH_RIFF) && (count_ff == whdp_pkg::RIFF_LAST);
      head_end    = (state_ff == whdp_pkg::PH_HEAD) && (count_ff == whdp_pkg::HEAD_LAST);
      fmt_end     = (state_ff == whdp_pkg::PH_FMT) && (count_ff == whdp_pkg::FMT_LAST);
      start_calc  = head_end && sts.tag_is_data;
      byte_emit   = 1'b0;
      byte_status = whdp_pkg::STATUS_BAD_HEADER;
      if (riff_end && !sts.header_good_next) begin
         byte_emit = 1'b1;
      end else if (head_end && !sts.tag_is_data && sts.tag_is_fmt && sts.len_next_short) begin
         byte_emit   = 1'b1;
         byte_status = whdp_pkg::STATUS_NO_DATA;
      end

      phase_after = state_ff;
      case (state_ff)
         whdp_pkg::PH_RIFF: begin
            if (riff_end) begin
               phase_after = sts.header_good_next ? whdp_pkg::PH_HEAD : whdp_pkg::PH_DONE;
            end
         end
         whdp_pkg::PH_HEAD: begin
            if (head_end) begin
               if (sts.tag_is_data) begin
                  phase_after = whdp_pkg::PH_MUL_A;
               end else if (sts.tag_is_fmt) begin
                  phase_after = sts.len_next_short ? whdp_pkg::PH_DONE : whdp_pkg::PH_FMT;
               end else begin
                  phase_after = sts.len_next_zero ? whdp_pkg::PH_HEAD : whdp_pkg::PH_SKIP;
               end
            end
         end
         whdp_pkg::PH_FMT: begin
            if (fmt_end) begin
               phase_after = sts.fmt_len_is16 ? whdp_pkg::PH_HEAD : whdp_pkg::PH_SKIP;
            end
         end
         whdp_pkg::PH_SKIP: begin
            if (sts.skip_leave) begin
               phase_after = whdp_pkg::PH_HEAD;
            end
         end
         default: phase_after = state_ff;
      endcase

      count_after = count_ff;
      if (state_ff inside {whdp_pkg::PH_RIFF, whdp_pkg::PH_HEAD, whdp_pkg::PH_FMT}) begin
         count_after = (riff_end || head_end) ? 4'd0 : count_ff + 4'd1;
      end

      eof_emit = req_tlast && !start_calc && !byte_emit && (state_ff != whdp_pkg::PH_DONE);
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      div_cnt_in     = div_cnt_ff;
      eof_pending_in = eof_pending_ff;
      case (state_ff)
         whdp_pkg::PH_MUL_A: state_in = whdp_pkg::PH_MUL_B;
         whdp_pkg::PH_MUL_B: state_in = whdp_pkg::PH_CHECK;
         whdp_pkg::PH_CHECK: begin
            if (sts.bps_zero) begin
               state_in       = eof_pending_ff ? whdp_pkg::PH_RIFF : whdp_pkg::PH_DONE;
               eof_pending_in = 1'b0;
            end else begin
               state_in   = whdp_pkg::PH_DIV;
               div_cnt_in = '0;
            end
         end
         whdp_pkg::PH_DIV: begin
            div_cnt_in = div_cnt_ff + whdp_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == whdp_pkg::DIV_LAST) begin
               state_in       = eof_pending_ff ? whdp_pkg::PH_RIFF : whdp_pkg::PH_DONE;
               eof_pending_in = 1'b0;
            end
         end
         default: begin
            if (accept) begin
               if (start_calc) begin
                  state_in       = whdp_pkg::PH_MUL_A;
                  count_in       = 4'd0;
                  eof_pending_in = req_tlast;
               end else if (req_tlast) begin
                  state_in = whdp_pkg::PH_RIFF;
                  count_in = 4'd0;
               end else begin
                  state_in = phase_after;
                  count_in = count_after;
               end
            end
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.count = count_ff;
      case (state_ff)
         whdp_pkg::PH_MUL_A: cmd.mul_a = 1'b1;
         whdp_pkg::PH_MUL_B: cmd.mul_b = 1'b1;
         whdp_pkg::PH_CHECK: begin
            if (sts.bps_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = whdp_pkg::STATUS_ZERO_RATE;
               cmd.clear       = eof_pending_ff;
            end else begin
               cmd.div_init = 1'b1;
            end
         end
         whdp_pkg::PH_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == whdp_pkg::DIV_LAST) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = whdp_pkg::STATUS_OK;
               cmd.emit_quot   = 1'b1;
               cmd.clear       = eof_pending_ff;
            end
         end
         default: begin
            if (accept) begin
               case (state_ff)
                  whdp_pkg::PH_RIFF: cmd.riff_step = 1'b1;
                  whdp_pkg::PH_HEAD: begin
                     cmd.head_step = 1'b1;
                     cmd.skip_load = head_end && !sts.tag_is_data && !sts.tag_is_fmt;
                  end
                  whdp_pkg::PH_FMT: begin
                     cmd.fmt_step   = 1'b1;
                     cmd.fmt_commit = fmt_end;
                  end
                  whdp_pkg::PH_SKIP: cmd.skip_step = 1'b1;
                  default: cmd.riff_step = 1'b0;
               endcase
               if (byte_emit) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = byte_status;
               end else if (eof_emit) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = (phase_after == whdp_pkg::PH_RIFF) ?
                                    whdp_pkg::STATUS_BAD_HEADER : whdp_pkg::STATUS_NO_DATA;
               end
               cmd.clear = req_tlast && !start_calc;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= whdp_pkg::PH_RIFF;
         count_ff       <= 4'd0;
         div_cnt_ff     <= '0;
         eof_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         div_cnt_ff     <= div_cnt_in;
         eof_pending_ff <= eof_pending_in;
      end
   end

endmodule

/* hw/rtl/whdp_datapath.sv */
module whdp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [7:0]                         req_byte,
   input  whdp_pkg::whdp_cmd_type             cmd,
   output whdp_pkg::whdp_sts_type             sts,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [whdp_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic        header_good_ff, header_good_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] chunk_length_ff, chunk_length_in;
   logic [31:0] skip_ff, skip_in;
   logic        pad_ff, pad_in;
   logic [15:0] new_ch_ff, new_ch_in;
   logic [31:0] new_rate_ff, new_rate_in;
   logic [7:0]  new_bits_lo_ff, new_bits_lo_in;
   logic [15:0] channel_ff, channel_in;
   logic [31:0] rate_seen_ff, rate_seen_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] bps_ff, bps_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_rate_ff, rsp_rate_in;
   logic [31:0] rsp_dur_ff, rsp_dur_in;

   logic [31:0] len_next;
   logic [31:0] rate_now;
   logic [32:0] partial;
   logic        take;

   always_comb begin
      len_next = {req_byte, chunk_length_ff[31:8]};
      rate_now = cmd.fmt_commit ? new_rate_ff : rate_seen_ff;
      partial  = {rem_ff, quo_ff[31]};
      take     = (partial >= {1'b0, bps_ff});

      sts.header_good_next = header_good_ff && !(whdp_pkg::riff_checked(cmd.count) &&
                             (req_byte != whdp_pkg::riff_byte(cmd.count)));
      sts.tag_is_data      = (chunk_tag_ff == whdp_pkg::TAG_DATA);
      sts.tag_is_fmt       = (chunk_tag_ff == whdp_pkg::TAG_FMT);
      sts.len_next_short   = (len_next < whdp_pkg::FMT_BODY_LEN);
      sts.len_next_zero    = (len_next == 32'd0);
      sts.fmt_len_is16     = (chunk_length_ff == whdp_pkg::FMT_BODY_LEN);
      sts.skip_leave       = (skip_ff == 32'd0) || ((skip_ff == 32'd1) && !pad_ff);
      sts.bps_zero         = (bps_ff == 32'd0);
      sts.out_free         = !rsp_valid_ff || rsp_tready;

      header_good_in  = header_good_ff;
      chunk_tag_in    = chunk_tag_ff;
      chunk_length_in = chunk_length_ff;
      skip_in         = skip_ff;
      pad_in          = pad_ff;
      new_ch_in       = new_ch_ff;
      new_rate_in     = new_rate_ff;
      new_bits_lo_in  = new_bits_lo_ff;
      channel_in      = channel_ff;
      rate_seen_in    = rate_seen_ff;
      bits_in         = bits_ff;
      prod_in         = prod_ff;
      bps_in          = bps_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;

      if (cmd.riff_step) begin
         header_good_in = sts.header_good_next;
      end
      if (cmd.head_step) begin
         if (cmd.count[2]) begin
            chunk_length_in = len_next;
         end else begin
            chunk_tag_in = {chunk_tag_ff[23:0], req_byte};
         end
      end
      if (cmd.skip_load) begin
         skip_in = len_next;
         pad_in  = len_next[0];
      end
      if (cmd.fmt_step) begin
         case (cmd.count)
            whdp_pkg::FMT_CH_LO:   new_ch_in[7:0]      = req_byte;
            whdp_pkg::FMT_CH_HI:   new_ch_in[15:8]     = req_byte;
            whdp_pkg::FMT_RATE_B0: new_rate_in[7:0]    = req_byte;
            whdp_pkg::FMT_RATE_B1: new_rate_in[15:8]   = req_byte;
            whdp_pkg::FMT_RATE_B2: new_rate_in[23:16]  = req_byte;
            whdp_pkg::FMT_RATE_B3: new_rate_in[31:24]  = req_byte;
            whdp_pkg::FMT_BITS_LO: new_bits_lo_in      = req_byte;
            default:               new_bits_lo_in      = new_bits_lo_ff;
         endcase
      end
      if (cmd.fmt_commit) begin
         channel_in   = new_ch_ff;
         rate_seen_in = new_rate_ff;
         bits_in      = {req_byte, new_bits_lo_ff};
         skip_in      = chunk_length_ff - whdp_pkg::FMT_BODY_LEN;
         pad_in       = chunk_length_ff[0];
      end
      if (cmd.skip_step) begin
         if (skip_ff != 32'd0) begin
            skip_in = skip_ff - 32'd1;
         end else begin
            pad_in = 1'b0;
         end
      end
      if (cmd.mul_a) begin
         prod_in = 32'(rate_seen_ff * 32'(channel_ff));
      end
      if (cmd.mul_b) begin
         bps_in = 32'(prod_ff * 32'(bits_ff[15:whdp_pkg::BYTE_SHIFT]));
      end
      if (cmd.div_init) begin
         rem_in = 32'd0;
         quo_in = chunk_length_ff;
      end
      if (cmd.div_step) begin
         rem_in = take ? 32'(partial - {1'b0, bps_ff}) : partial[31:0];
         quo_in = {quo_ff[30:0], take};
      end
      if (cmd.clear) begin
         header_good_in = 1'b1;
         channel_in     = 16'd0;
         rate_seen_in   = 32'd0;
         bits_in        = 16'd0;
      end

      rsp_status_in = rsp_status_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_dur_in    = rsp_dur_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.emit_status;
         rsp_rate_in   = (cmd.emit_status == whdp_pkg::STATUS_BAD_HEADER) ? 32'd0 : rate_now;
         rsp_dur_in    = cmd.emit_quot ? quo_in : 32'd0;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_good_ff <= 1'b1;
         channel_ff     <= 16'd0;
         rate_seen_ff   <= 32'd0;
         bits_ff        <= 16'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         header_good_ff <= header_good_in;
         channel_ff     <= channel_in;
         rate_seen_ff   <= rate_seen_in;
         bits_ff        <= bits_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_tag_ff    <= chunk_tag_in;
      chunk_length_ff <= chunk_length_in;
      skip_ff         <= skip_in;
      pad_ff          <= pad_in;
      new_ch_ff       <= new_ch_in;
      new_rate_ff     <= new_rate_in;
      new_bits_lo_ff  <= new_bits_lo_in;
      prod_ff         <= prod_in;
      bps_ff          <= bps_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_rate_ff     <= rsp_rate_in;
      rsp_dur_ff      <= rsp_dur_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_dur_ff, rsp_rate_ff, rsp_status_ff};

endmodule

/* hw/rtl/wav_header_duration_parser.sv */
// Takes one file byte per cycle while no calculation runs and the result slot is free;
// a result is registered in the cycle after the byte that causes it. When the data chunk
// header completes, the byte rate is formed in states MUL_A and MUL_B and checked, then a
// radix-2 divider runs, with input held off meanwhile. A zero byte rate gives a zero-rate status.
// Synchronous reset returns the parser to the RIFF header phase with no result pending.
`include "wav_header_duration_parser_macros.svh"

module wav_header_duration_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // file_byte
   input  logic                             req_tlast,  // end_of_file
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [whdp_pkg::RSP_TDATA_W-1:0] rsp_tdata   // status, sample_rate, duration_sec
);

   whdp_pkg::whdp_cmd_type cmd;
   whdp_pkg::whdp_sts_type sts;
   logic                   calc_busy;

   whdp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   whdp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign calc_busy = cmd.mul_a || cmd.mul_b || cmd.div_init || cmd.div_step;

   `WHDP_ASSERT_IMPLY(a_emit_slot_free, clock, reset, cmd.emit, sts.out_free, "result overwritten")
   `WHDP_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_tvalid, "result not presented")
   `WHDP_ASSERT_IMPLY(a_calc_no_input, clock, reset, calc_busy, !req_tready, "input during divide")

endmodule
